/* hw/rtl/ltag_pkg.sv */
`timescale 1ns / 1ps

package ltag_pkg;

    // edge components are exact differences of two 32 bit coordinates
    localparam int EDGE_W   = 33;
    // quotient bits kept by the gradient divider, one past the 32 bit result range
    localparam int QUO_BITS = 33;

    localparam logic [31:0] GRAD_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] GRAD_MIN = 32'h8000_0000;
    localparam logic [30:0] AREA_MAX = 31'h7FFF_FFFF;

    typedef struct packed {
        logic                ovf;
        logic [QUO_BITS-1:0] quo;
    } ltag_quo_t;

endpackage

/* hw/rtl/lifted_triangle_area_gradient.sv */
`timescale 1ns / 1ps
// channel  | dir | payload                                                  | handshake
// s_*      | in  | tdata: three vertices, three lifts                       | tvalid/tready
// m_*      | out | tdata: area, six gradients; tuser: degenerate, saturated  | tvalid/tready
//
// one triangle per cycle unless the output is held (Q16.16 at FRAC_BITS = 16)
// most of the pipeline depth lies in the square root (one root bit per stage)
// and the gradient divider
// reset clears the valid bits only
// a held output freezes the whole pipeline; nothing is dropped or repeated
module lifted_triangle_area_gradient
    import ltag_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // x_first, y_first, x_second, y_second, x_third, y_third,
    // lift_first, lift_second, lift_third (32 bits each)
    input  logic [287:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // tri_area(31), grad_x_first, grad_y_first, grad_x_second, grad_y_second,
    // grad_x_third, grad_y_third (32 bits each), one zero pad bit
    output logic [223:0] m_tdata,
    // degenerate, saturated
    output logic [1:0]   m_tuser
);

    localparam int DW   = 68 - FRAC_BITS;      // signed lifted length
    localparam int M    = DW - 1;              // its magnitude
    localparam int GW   = DW + 1;              // signed edge weight
    localparam int GMW  = GW - 1;
    localparam int SQW  = M + 2;               // root bits
    localparam int PW   = 2 * SQW;             // product form width
    localparam int RW   = SQW + 2;             // root remainder
    localparam int PSUM = 2 * M + 2;
    localparam int PGW  = GMW + EDGE_W;
    localparam int SGW  = PGW + 1;
    localparam int AVW  = PGW + 2;
    localparam int NW   = PGW + 1;
    localparam int DVW  = M + 3;
    localparam int LAT  = SQW + QUO_BITS + 13;

    localparam int DA [6] = '{0, 1, 2, 0, 1, 2};
    localparam int DB [6] = '{1, 2, 0, 0, 1, 2};
    localparam int UP [3] = '{2, 0, 1};
    localparam int DN [3] = '{1, 2, 0};

    typedef struct packed {
        logic [2:0]              sx;
        logic [2:0]              sy;
        logic [2:0][EDGE_W-1:0]  mx;
        logic [2:0][EDGE_W-1:0]  my;
    } edge_t;

    typedef struct packed {
        logic                neg;
        logic [5:0]          sgn;
        logic [5:0][NW-1:0]  mag;
    } carry_t;

    typedef struct packed {
        logic        deg;
        logic        asat;
        logic [5:0]  sgn;
        logic [30:0] tri_a;
    } side_t;

    logic            adv;
    logic [LAT-1:0]  vld_reg;

    // stage 1..5
    logic [2:0][31:0]        vx, vy, lift_in;
    logic [2:0][EDGE_W-1:0]  ex, ey;
    edge_t                   edge_next [5];
    edge_t                   edge_reg  [5];
    logic [2:0][31:0]        lift_next [3];
    logic [2:0][31:0]        lift_reg  [3];
    logic [2*EDGE_W-1:0]     sqx [3];
    logic [2*EDGE_W-1:0]     sqy [3];
    logic [2:0][DW+FRAC_BITS-1:0] ssum;
    logic [2:0][DW-1:0]      d_next, d_reg;
    logic [2:0][GW-1:0]      g_c;
    logic [2:0][GMW-1:0]     gm_next, gm_reg;
    logic [2:0][M-1:0]       dm_next, dm_reg;
    logic [5:0]              sg_next [3];
    logic [5:0]              sg_reg  [3];
    logic                    neg_next [5];
    logic                    neg_reg  [5];

    // stage 6..10
    logic [2*M-1:0]          dd [6];
    logic [PGW-1:0]          ge [6];
    logic [PSUM-1:0]         cross_next, cross_reg, sqs_next, sqs_reg;
    logic [5:0][SGW-1:0]     sgp_next, sgp_reg;
    logic [PW-1:0]           p_next, p_reg;
    logic [5:0][AVW-1:0]     av_next, av_reg;

    // square root
    logic [PW-1:0]   sq_x_next    [SQW+1];
    logic [PW-1:0]   sq_x_reg     [SQW+1];
    logic [RW-1:0]   sq_rem_next  [SQW+1];
    logic [RW-1:0]   sq_rem_reg   [SQW+1];
    logic [SQW-1:0]  sq_root_next [SQW+1];
    logic [SQW-1:0]  sq_root_reg  [SQW+1];
    carry_t          sq_c_next    [SQW+1];
    carry_t          sq_c_reg     [SQW+1];

    // area and divider
    logic [M-1:0]          area_c;
    side_t                 side_next [QUO_BITS+2];
    side_t                 side_reg  [QUO_BITS+2];
    logic [5:0][NW-1:0]    num_reg;
    logic [DVW-1:0]        den_reg;
    ltag_quo_t             quo_res [6];

    // output
    logic [30:0]       tri_out_next, tri_out_reg;
    logic [5:0][31:0]  grad_out_next, grad_out_reg;
    logic              deg_out_next, deg_out_reg;
    logic              sat_out_next, sat_out_reg;

    assign adv      = !vld_reg[LAT-1] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
        end
    end

    // edges and their magnitudes
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            vx[k]      = s_tdata[64*k +: 32];
            vy[k]      = s_tdata[64*k+32 +: 32];
            lift_in[k] = s_tdata[192+32*k +: 32];
        end
        ex[0] = {vx[1][31], vx[1]} - {vx[2][31], vx[2]};
        ex[1] = {vx[2][31], vx[2]} - {vx[0][31], vx[0]};
        ex[2] = {vx[0][31], vx[0]} - {vx[1][31], vx[1]};
        ey[0] = {vy[1][31], vy[1]} - {vy[2][31], vy[2]};
        ey[1] = {vy[2][31], vy[2]} - {vy[0][31], vy[0]};
        ey[2] = {vy[0][31], vy[0]} - {vy[1][31], vy[1]};
        for (int k = 0; k < 3; k++)
        begin
            edge_next[0].sx[k] = ex[k][EDGE_W-1];
            edge_next[0].sy[k] = ey[k][EDGE_W-1];
            edge_next[0].mx[k] = ex[k][EDGE_W-1] ? ~ex[k] + 1'b1 : ex[k];
            edge_next[0].my[k] = ey[k][EDGE_W-1] ? ~ey[k] + 1'b1 : ey[k];
        end
        for (int i = 1; i < 5; i++)
        begin
            edge_next[i] = edge_reg[i-1];
        end
        lift_next[0] = lift_in;
        lift_next[1] = lift_reg[0];
        lift_next[2] = lift_reg[1];
    end

    generate
        for (genvar k = 0; k < 3; k++)
        begin : g_sq
            ltag_mul #(.AW(EDGE_W), .BW(EDGE_W)) u_sqx
            (
                .clk (clk),
                .en  (adv),
                .a   (edge_reg[0].mx[k]),
                .b   (edge_reg[0].mx[k]),
                .p   (sqx[k])
            );
            ltag_mul #(.AW(EDGE_W), .BW(EDGE_W)) u_sqy
            (
                .clk (clk),
                .en  (adv),
                .a   (edge_reg[0].my[k]),
                .b   (edge_reg[0].my[k]),
                .p   (sqy[k])
            );
        end
    endgenerate

    // lifted lengths and edge weights
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            ssum[k]   = (DW+FRAC_BITS)'(sqx[k]) + (DW+FRAC_BITS)'(sqy[k]);
            d_next[k] = ssum[k][DW+FRAC_BITS-1:FRAC_BITS]
                      + {{(DW-32){lift_reg[2][k][31]}}, lift_reg[2][k]};
        end
        g_c[0] = {d_reg[1][DW-1], d_reg[1]} + {d_reg[2][DW-1], d_reg[2]}
               - {d_reg[0][DW-1], d_reg[0]};
        g_c[1] = {d_reg[2][DW-1], d_reg[2]} + {d_reg[0][DW-1], d_reg[0]}
               - {d_reg[1][DW-1], d_reg[1]};
        g_c[2] = {d_reg[0][DW-1], d_reg[0]} + {d_reg[1][DW-1], d_reg[1]}
               - {d_reg[2][DW-1], d_reg[2]};
        for (int k = 0; k < 3; k++)
        begin
            gm_next[k] = g_c[k][GW-1] ? GMW'(~g_c[k] + 1'b1) : g_c[k][GMW-1:0];
            dm_next[k] = d_reg[k][M-1:0];
            sg_next[0][2*k]   = g_c[k][GW-1] ^ edge_reg[3].sx[k];
            sg_next[0][2*k+1] = g_c[k][GW-1] ^ edge_reg[3].sy[k];
        end
        sg_next[1]  = sg_reg[0];
        sg_next[2]  = sg_reg[1];
        neg_next[0] = d_reg[0][DW-1] || d_reg[1][DW-1] || d_reg[2][DW-1];
        for (int i = 1; i < 5; i++)
        begin
            neg_next[i] = neg_reg[i-1];
        end
    end

    generate
        for (genvar i = 0; i < 6; i++)
        begin : g_dd
            ltag_mul #(.AW(M), .BW(M)) u_dd
            (
                .clk (clk),
                .en  (adv),
                .a   (dm_reg[DA[i]]),
                .b   (dm_reg[DB[i]]),
                .p   (dd[i])
            );
        end
        for (genvar k = 0; k < 3; k++)
        begin : g_ge
            ltag_mul #(.AW(GMW), .BW(EDGE_W)) u_gex
            (
                .clk (clk),
                .en  (adv),
                .a   (gm_reg[k]),
                .b   (edge_reg[4].mx[k]),
                .p   (ge[2*k])
            );
            ltag_mul #(.AW(GMW), .BW(EDGE_W)) u_gey
            (
                .clk (clk),
                .en  (adv),
                .a   (gm_reg[k]),
                .b   (edge_reg[4].my[k]),
                .p   (ge[2*k+1])
            );
        end
    endgenerate

    // product form and weighted edge differences
    always_comb
    begin
        cross_next = PSUM'(dd[0]) + PSUM'(dd[1]) + PSUM'(dd[2]);
        sqs_next   = PSUM'(dd[3]) + PSUM'(dd[4]) + PSUM'(dd[5]);
        for (int i = 0; i < 6; i++)
        begin
            sgp_next[i] = sg_reg[2][i] ? ~{1'b0, ge[i]} + 1'b1 : {1'b0, ge[i]};
        end
        p_next = PW'({cross_reg, 1'b0}) - PW'(sqs_reg);
        for (int k = 0; k < 3; k++)
        begin
            for (int c = 0; c < 2; c++)
            begin
                av_next[2*k+c] = {sgp_reg[2*UP[k]+c][SGW-1], sgp_reg[2*UP[k]+c]}
                               - {sgp_reg[2*DN[k]+c][SGW-1], sgp_reg[2*DN[k]+c]};
            end
        end
    end

    // digit-by-digit square root of |P|
    always_comb
    begin
        logic [RW-1:0] t;
        logic [RW-1:0] trial;
        logic          hit;
        sq_x_next[0]    = p_reg[PW-1] ? ~p_reg + 1'b1 : p_reg;
        sq_rem_next[0]  = '0;
        sq_root_next[0] = '0;
        sq_c_next[0].neg = neg_reg[4];
        for (int i = 0; i < 6; i++)
        begin
            sq_c_next[0].sgn[i] = av_reg[i][AVW-1];
            sq_c_next[0].mag[i] = av_reg[i][AVW-1] ? NW'(~av_reg[i] + 1'b1)
                                                   : av_reg[i][NW-1:0];
        end
        for (int j = 1; j <= SQW; j++)
        begin
            t     = {sq_rem_reg[j-1][RW-3:0], sq_x_reg[j-1][PW-1 -: 2]};
            trial = {sq_root_reg[j-1], 2'b01};
            hit   = t >= trial;
            sq_rem_next[j]  = hit ? t - trial : t;
            sq_root_next[j] = {sq_root_reg[j-1][SQW-2:0], hit};
            sq_x_next[j]    = sq_x_reg[j-1] << 2;
            sq_c_next[j]    = sq_c_reg[j-1];
        end
    end

    // area, clip and divider setup
    always_comb
    begin
        area_c = sq_root_reg[SQW][SQW-1:2];
        side_next[0].deg   = sq_c_reg[SQW].neg || (area_c == '0);
        side_next[0].asat  = |area_c[M-1:31];
        side_next[0].tri_a = (|area_c[M-1:31]) ? AREA_MAX : area_c[30:0];
        side_next[0].sgn   = sq_c_reg[SQW].sgn;
        for (int i = 1; i < QUO_BITS + 2; i++)
        begin
            side_next[i] = side_reg[i-1];
        end
    end

    generate
        for (genvar i = 0; i < 6; i++)
        begin : g_div
            ltag_div #(.NW(NW), .DVW(DVW)) u_div
            (
                .clk (clk),
                .en  (adv),
                .num (num_reg[i]),
                .den (den_reg),
                .res (quo_res[i])
            );
        end
    endgenerate

    // gradient clip and degenerate override
    always_comb
    begin
        side_t s;
        logic  sat;
        s   = side_reg[QUO_BITS+1];
        sat = s.asat;
        for (int i = 0; i < 6; i++)
        begin
            if (!s.sgn[i])
            begin
                if (quo_res[i].ovf || quo_res[i].quo > {1'b0, GRAD_MAX})
                begin
                    grad_out_next[i] = GRAD_MAX;
                    sat = 1'b1;
                end
                else
                begin
                    grad_out_next[i] = quo_res[i].quo[31:0];
                end
            end
            else
            begin
                if (quo_res[i].ovf || quo_res[i].quo > {1'b0, GRAD_MIN})
                begin
                    grad_out_next[i] = GRAD_MIN;
                    sat = 1'b1;
                end
                else
                begin
                    grad_out_next[i] = ~quo_res[i].quo[31:0] + 1'b1;
                end
            end
        end
        tri_out_next = s.tri_a;
        deg_out_next = s.deg;
        sat_out_next = sat;
        if (s.deg)
        begin
            grad_out_next = '0;
            tri_out_next  = '0;
            sat_out_next  = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 5; i++)
            begin
                edge_reg[i] <= edge_next[i];
                neg_reg[i]  <= neg_next[i];
            end
            for (int i = 0; i < 3; i++)
            begin
                lift_reg[i] <= lift_next[i];
                sg_reg[i]   <= sg_next[i];
            end
            d_reg     <= d_next;
            gm_reg    <= gm_next;
            dm_reg    <= dm_next;
            cross_reg <= cross_next;
            sqs_reg   <= sqs_next;
            sgp_reg   <= sgp_next;
            p_reg     <= p_next;
            av_reg    <= av_next;
            for (int j = 0; j <= SQW; j++)
            begin
                sq_x_reg[j]    <= sq_x_next[j];
                sq_rem_reg[j]  <= sq_rem_next[j];
                sq_root_reg[j] <= sq_root_next[j];
                sq_c_reg[j]    <= sq_c_next[j];
            end
            for (int i = 0; i < QUO_BITS + 2; i++)
            begin
                side_reg[i] <= side_next[i];
            end
            num_reg      <= sq_c_reg[SQW].mag;
            den_reg      <= {area_c, 3'b000};
            tri_out_reg  <= tri_out_next;
            grad_out_reg <= grad_out_next;
            deg_out_reg  <= deg_out_next;
            sat_out_reg  <= sat_out_next;
        end
    end

    assign m_tdata = {1'b0, grad_out_reg, tri_out_reg};
    assign m_tuser = {sat_out_reg, deg_out_reg};

    a_accept_enters : assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> vld_reg[0])
        else $error("accepted request did not enter the pipeline");

    a_stall_freezes : assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg))
        else $error("pipeline moved during a stall");

    a_degenerate_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && deg_out_reg) |->
        (grad_out_reg == '0 && tri_out_reg == '0 && !sat_out_reg))
        else $error("degenerate result carries nonzero fields");

    a_area_nonzero : assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !deg_out_reg) |-> (tri_out_reg != '0))
        else $error("zero area without degenerate flag");

endmodule

/* hw/rtl/ltag_mul.sv */
`timescale 1ns / 1ps

// unsigned product over two stages: half-width partial products, then their sum
module ltag_mul
#(
    parameter int AW = 32,
    parameter int BW = 32
)
(
    input  logic             clk,
    input  logic             en,
    input  logic [AW-1:0]    a,
    input  logic [BW-1:0]    b,
    output logic [AW+BW-1:0] p
);

    localparam int AL  = (AW + 1) / 2;
    localparam int AH  = AW - AL;
    localparam int BL  = (BW + 1) / 2;
    localparam int BH  = BW - BL;
    localparam int PWD = AW + BW;

    logic [AL+BL-1:0] ll_next, ll_reg;
    logic [AL+BH-1:0] lh_next, lh_reg;
    logic [AH+BL-1:0] hl_next, hl_reg;
    logic [AH+BH-1:0] hh_next, hh_reg;
    logic [PWD-1:0]   p_next, p_reg;

    always_comb
    begin
        ll_next = (AL+BL)'(a[AL-1:0]) * (AL+BL)'(b[BL-1:0]);
        lh_next = (AL+BH)'(a[AL-1:0]) * (AL+BH)'(b[BW-1:BL]);
        hl_next = (AH+BL)'(a[AW-1:AL]) * (AH+BL)'(b[BL-1:0]);
        hh_next = (AH+BH)'(a[AW-1:AL]) * (AH+BH)'(b[BW-1:BL]);
    end

    always_comb
    begin
        p_next = (PWD'(hh_reg) << (AL + BL)) + (PWD'(lh_reg) << BL)
               + (PWD'(hl_reg) << AL) + PWD'(ll_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ll_reg <= ll_next;
            lh_reg <= lh_next;
            hl_reg <= hl_next;
            hh_reg <= hh_next;
            p_reg  <= p_next;
        end
    end

    assign p = p_reg;

endmodule

/* hw/rtl/ltag_div.sv */
`timescale 1ns / 1ps

// restoring divider, one quotient bit per stage, with an overflow check up front
module ltag_div
    import ltag_pkg::*;
#(
    parameter int NW  = 86,
    parameter int DVW = 54
)
(
    input  logic           clk,
    input  logic           en,
    input  logic [NW-1:0]  num,
    input  logic [DVW-1:0] den,
    output ltag_quo_t      res
);

    localparam int CW = (NW > DVW + QUO_BITS) ? NW : DVW + QUO_BITS;

    logic [CW-1:0]       rem_next [QUO_BITS+1];
    logic [CW-1:0]       rem_reg  [QUO_BITS+1];
    logic [DVW-1:0]      den_next [QUO_BITS+1];
    logic [DVW-1:0]      den_reg  [QUO_BITS+1];
    logic [QUO_BITS-1:0] quo_next [QUO_BITS+1];
    logic [QUO_BITS-1:0] quo_reg  [QUO_BITS+1];
    logic                ovf_next [QUO_BITS+1];
    logic                ovf_reg  [QUO_BITS+1];

    always_comb
    begin
        logic [CW-1:0] sub;
        logic          hit;
        rem_next[0] = CW'(num);
        den_next[0] = den;
        quo_next[0] = '0;
        // quotient of 2^QUO_BITS or more only matters as a clip
        ovf_next[0] = CW'(num) >= (CW'(den) << QUO_BITS);
        for (int j = 1; j <= QUO_BITS; j++)
        begin
            sub         = CW'(den_reg[j-1]) << (QUO_BITS - j);
            hit         = rem_reg[j-1] >= sub;
            rem_next[j] = hit ? rem_reg[j-1] - sub : rem_reg[j-1];
            den_next[j] = den_reg[j-1];
            quo_next[j] = quo_reg[j-1];
            quo_next[j][QUO_BITS-j] = hit;
            ovf_next[j] = ovf_reg[j-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j <= QUO_BITS; j++)
            begin
                rem_reg[j] <= rem_next[j];
                den_reg[j] <= den_next[j];
                quo_reg[j] <= quo_next[j];
                ovf_reg[j] <= ovf_next[j];
            end
        end
    end

    assign res.ovf = ovf_reg[QUO_BITS];
    assign res.quo = quo_reg[QUO_BITS];

endmodule
